@@ hdl/trie_pkg.sv @@
// ----------------------------------------------------------------------------
// trie_pkg
// Shared constants and the command/status bundles between the trie
// controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package trie_pkg;

  localparam int NODE_COUNT_DEF = 4096;
  localparam int ALPHABET_DEF   = 26;
  localparam int LETTER_W       = 5;
  localparam int NODE_OUT_W     = 12;
  localparam int COUNT_W        = 16;

  typedef struct packed {
    logic init_root;  // write an empty row for the root
    logic accept;     // take a request, read the cursor row
    logic look;       // child row data is valid, decide hit/alloc/miss
    logic zero;       // write the empty row of a new node
    logic count;      // count data is valid, bump and finish a hit
  } trie_cmd_t;

  typedef struct packed {
    logic hit;
    logic alloc;
    logic out_free;
  } trie_stat_t;

endpackage

`default_nettype wire

@@ hdl/trie_ram.sv @@
// ----------------------------------------------------------------------------
// trie_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ hdl/trie_ctrl.sv @@
// ----------------------------------------------------------------------------
// trie_ctrl
// Sequencer for one letter: row lookup, then allocation, count update or a finish on a miss.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire trie_pkg::trie_stat_t  stat,
  output      trie_pkg::trie_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOOK,
    S_ZERO,
    S_COUNT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE) && stat.out_free;

  always_comb begin
    cmd           = '0;
    cmd.init_root = (state == S_INIT);
    cmd.accept    = in_valid && in_ready;
    cmd.look      = (state == S_LOOK);
    cmd.zero      = (state == S_ZERO);
    cmd.count     = (state == S_COUNT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      unique case (state)
        S_INIT:  state <= S_IDLE;
        S_IDLE:  if (in_valid && in_ready) state <= S_LOOK;
        S_LOOK: begin
          priority if (stat.hit)   state <= S_COUNT;
          else if     (stat.alloc) state <= S_ZERO;
          else                     state <= S_IDLE;
        end
        S_ZERO:  state <= S_IDLE;
        S_COUNT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/trie_dp.sv @@
// ----------------------------------------------------------------------------
// trie_dp
// Trie datapath: child-row RAM, word-count RAM, cursor, miss latch,
// node allocator and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_dp #(
  parameter int NODE_COUNT = trie_pkg::NODE_COUNT_DEF,
  parameter int ALPHABET   = trie_pkg::ALPHABET_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire trie_pkg::trie_cmd_t               cmd,
  output      trie_pkg::trie_stat_t              stat,
  input  wire logic                              opcode,
  input  wire logic [trie_pkg::LETTER_W-1:0]     letter,
  input  wire logic                              word_end,
  input  wire logic                              out_ready,
  output      logic                              out_valid,
  output      logic                              present,
  output      logic [trie_pkg::NODE_OUT_W-1:0]   node_index,
  output      logic [trie_pkg::COUNT_W-1:0]      word_count,
  output      logic                              table_full,
  output      logic                              last
);

  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int LW      = $clog2(ALPHABET);
  localparam int ROW_W   = ALPHABET * NODE_W;
  localparam int COUNT_W = trie_pkg::COUNT_W;

  typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

  // request and walk state
  logic                          op_r;
  logic [trie_pkg::LETTER_W-1:0] letter_r;
  logic                          end_r;
  logic [NODE_W-1:0]             cursor;
  logic                          missed;
  logic [NODE_W-1:0]             nodes_used;
  logic [NODE_W-1:0]             node_r;

  // memories
  logic              row_we;
  logic [NODE_W-1:0] row_addr;
  logic [ROW_W-1:0]  row_wdata;
  logic [ROW_W-1:0]  row_rdata;
  logic              cnt_we;
  logic [NODE_W-1:0] cnt_addr;
  logic [COUNT_W-1:0] cnt_wdata;
  logic [COUNT_W-1:0] cnt_rdata;

  row_t              row_q;
  row_t              row_upd;
  logic [LW-1:0]     lit;
  logic              ok;
  logic [NODE_W-1:0] child;
  logic [NODE_W-1:0] new_node;
  logic              room;
  logic              hit;
  logic              alloc;
  logic              inc;
  logic [COUNT_W-1:0] cnt_val;
  logic [COUNT_W-1:0] cnt_init;
  logic              fin_miss;
  logic              finalize;

  assign row_q    = row_t'(row_rdata);
  assign lit      = LW'(letter_r);
  assign ok       = int'(letter_r) < ALPHABET;
  assign child    = ok ? row_q[lit] : '0;
  assign new_node = nodes_used + 1'b1;
  assign room     = nodes_used != NODE_W'(NODE_COUNT - 1);
  assign hit      = !missed && (child != '0);
  assign alloc    = !missed && ok && (child == '0) && !op_r && room;

  assign inc      = !op_r && end_r && (cnt_rdata != '1);
  assign cnt_val  = cnt_rdata + COUNT_W'(inc);
  assign cnt_init = COUNT_W'(end_r);

  assign fin_miss = cmd.look && !hit && !alloc;
  assign finalize = fin_miss || cmd.zero || cmd.count;

  assign stat.hit      = hit;
  assign stat.alloc    = alloc;
  assign stat.out_free = !out_valid || out_ready;

  always_comb begin
    row_upd      = row_q;
    row_upd[lit] = new_node;
  end

  always_comb begin
    row_we = cmd.init_root || (cmd.look && alloc) || cmd.zero;
    priority if (cmd.init_root) row_addr = '0;
    else if (cmd.zero)          row_addr = node_r;
    else                        row_addr = cursor;
    row_wdata = (cmd.look && alloc) ? ROW_W'(row_upd) : '0;
  end

  always_comb begin
    cnt_we    = cmd.zero || (cmd.count && inc);
    cnt_addr  = cmd.look ? child : node_r;
    cnt_wdata = cmd.zero ? cnt_init : cnt_val;
  end

  trie_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NODE_COUNT)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .addr  (row_addr),
    .wdata (row_wdata),
    .rdata (row_rdata)
  );

  trie_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NODE_COUNT)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .addr  (cnt_addr),
    .wdata (cnt_wdata),
    .rdata (cnt_rdata)
  );

  // request latch and node pick
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= opcode;
      letter_r <= letter;
      end_r    <= word_end;
    end
    if (cmd.look) begin
      node_r <= hit ? child : new_node;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor     <= '0;
      missed     <= 1'b0;
      nodes_used <= '0;
    end else begin
      if (cmd.look && alloc) begin
        nodes_used <= new_node;
      end
      if (finalize) begin
        // a word end always returns to the root and drops the miss
        priority if (end_r) begin
          cursor <= '0;
          missed <= 1'b0;
        end else if (fin_miss) begin
          missed <= 1'b1;
        end else begin
          cursor <= node_r;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finalize) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finalize) begin
      present    <= cmd.count;
      node_index <= fin_miss ? '0 : trie_pkg::NODE_OUT_W'(node_r);
      table_full <= fin_miss && !op_r;
      last       <= end_r;
      priority if (fin_miss) word_count <= '0;
      else if (cmd.zero)     word_count <= cnt_init;
      else                   word_count <= cnt_val;
    end
  end

endmodule

`default_nettype wire

@@ hdl/trie_insert_and_prefix_search.sv @@
// ----------------------------------------------------------------------------
// trie_insert_and_prefix_search
// Letter-serial array trie with insert and prefix search.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one letter per request with its
// opcode (insert or search) and a word_end flag. Output channel
// (out_valid/out_ready) returns one result per request: present, node_index,
// word_count, table_full and last.
// A request that follows an existing child passes a row lookup and a count
// update on its way to the result register; one that allocates a node passes
// a row lookup with parent write and a new-row clear; a miss ends at the lookup.
// The single-port child-row RAM sets this sequence; the next request is taken
// in the cycle after the result is loaded, if the output register is free.
// After reset the block clears the root row, then accepts.
// A result waits in the output register while the receiver stalls; no new
// request is taken until that register is free or being emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_insert_and_prefix_search #(
  parameter int NODE_COUNT = trie_pkg::NODE_COUNT_DEF,
  parameter int ALPHABET   = trie_pkg::ALPHABET_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic                            opcode,
  input  wire logic [trie_pkg::LETTER_W-1:0]   letter,
  input  wire logic                            word_end,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic                            present,
  output      logic [trie_pkg::NODE_OUT_W-1:0] node_index,
  output      logic [trie_pkg::COUNT_W-1:0]    word_count,
  output      logic                            table_full,
  output      logic                            last
);

  trie_pkg::trie_cmd_t  cmd;
  trie_pkg::trie_stat_t stat;

  trie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  trie_dp #(
    .NODE_COUNT (NODE_COUNT),
    .ALPHABET   (ALPHABET)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .opcode     (opcode),
    .letter     (letter),
    .word_end   (word_end),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .present    (present),
    .node_index (node_index),
    .word_count (word_count),
    .table_full (table_full),
    .last       (last)
  );

endmodule

`default_nettype wire

@@ hdl/trie_chk.sv @@
// ----------------------------------------------------------------------------
// trie_chk
// Port-level checks for the trie block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_chk (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic                            present,
  input wire logic [trie_pkg::NODE_OUT_W-1:0] node_index,
  input wire logic [trie_pkg::COUNT_W-1:0]    word_count,
  input wire logic                            table_full,
  input wire logic                            last
);

  // no result may appear straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(present) &&
      $stable(node_index) && $stable(word_count) && $stable(table_full) &&
      $stable(last))
    else $error("stalled result changed");

  // one request at a time: busy after taking one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_full_is_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !present && node_index == '0 && word_count == '0)
    else $error("full result carries a node");

  a_miss_no_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !present && node_index == '0 |-> word_count == '0)
    else $error("missed result carries a count");

endmodule

bind trie_insert_and_prefix_search trie_chk u_chk (.*);

`default_nettype wire

@@ verif/tb_trie_insert_and_prefix_search.sv @@
// ----------------------------------------------------------------------------
// tb_trie_insert_and_prefix_search
// Self-checking bench for the letter-serial trie with insert and prefix search.
// ----------------------------------------------------------------------------
// A short table of hand-picked requests opens the run. Rows whose answer is
// obvious carry it; the rest go through a behavioural copy of the trie kept
// in the bench. Random words follow: inserts, searches of stored words and
// their prefixes, unknown words, out-of-range letters and stray letters.
// The sender idles in bursts. The receiver stalls on its own pattern and
// once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_trie_insert_and_prefix_search;

  localparam int LETTER_W       = trie_pkg::LETTER_W;
  localparam int NODE_OUT_W     = trie_pkg::NODE_OUT_W;
  localparam int COUNT_W        = trie_pkg::COUNT_W;
  localparam int NODES          = trie_pkg::NODE_COUNT_DEF;
  localparam int ALPHA          = trie_pkg::ALPHABET_DEF;
  localparam int RANDOM_ITEMS   = 800;
  localparam int HOLD_AT        = 300;
  localparam int PAUSE_AT       = 550;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;
  localparam int DICT_SIZE      = 64;

  localparam logic [LETTER_W-1:0] LTR_A      = 5'd0;
  localparam logic [LETTER_W-1:0] LTR_B      = 5'd1;
  localparam logic [LETTER_W-1:0] LTR_C      = 5'd2;
  localparam logic [LETTER_W-1:0] LTR_Q      = 5'd16;
  localparam logic [LETTER_W-1:0] LTR_Z      = 5'd25;
  localparam logic [LETTER_W-1:0] LTR_BAD_LO = 5'd26;
  localparam logic [LETTER_W-1:0] LTR_BAD_HI = 5'd31;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef struct packed {
    logic                  present;
    logic [NODE_OUT_W-1:0] node_index;
    logic [COUNT_W-1:0]    word_count;
    logic                  table_full;
    logic                  last;
  } result_t;

  typedef struct packed {
    logic    known;
    result_t res;
  } answer_t;

  typedef struct packed {
    logic [3:0]                 len;
    logic [15:0][LETTER_W-1:0]  ltr;
  } word_t;

  typedef struct packed {
    op_e                   op;
    logic [LETTER_W-1:0]   ltr;
    logic                  we;
    logic                  known;
    logic                  present;
    logic [NODE_OUT_W-1:0] node;
    logic [COUNT_W-1:0]    count;
    logic                  full;
  } step_row_t;

  localparam answer_t NO_ANSWER = '0;
  localparam int      NUM_STEPS = 19;

  // op, letter, word_end, answer known, present, node, count, full
  step_row_t directed_steps [0:NUM_STEPS-1] = '{
    '{OP_INSERT, LTR_A,      1'b1, 1'b1, 1'b0, 12'd1, 16'd1, 1'b0},
    '{OP_SEARCH, LTR_A,      1'b1, 1'b1, 1'b1, 12'd1, 16'd1, 1'b0},
    '{OP_INSERT, LTR_Z,      1'b0, 1'b1, 1'b0, 12'd2, 16'd0, 1'b0},
    '{OP_INSERT, LTR_A,      1'b1, 1'b1, 1'b0, 12'd3, 16'd1, 1'b0},
    '{OP_SEARCH, LTR_Z,      1'b0, 1'b1, 1'b1, 12'd2, 16'd0, 1'b0},
    '{OP_SEARCH, LTR_A,      1'b1, 1'b1, 1'b1, 12'd3, 16'd1, 1'b0},
    '{OP_SEARCH, LTR_BAD_HI, 1'b1, 1'b1, 1'b0, 12'd0, 16'd0, 1'b0},
    '{OP_INSERT, LTR_BAD_LO, 1'b1, 1'b1, 1'b0, 12'd0, 16'd0, 1'b1},
    '{OP_INSERT, LTR_BAD_HI, 1'b0, 1'b1, 1'b0, 12'd0, 16'd0, 1'b1},
    '{OP_INSERT, LTR_B,      1'b1, 1'b1, 1'b0, 12'd0, 16'd0, 1'b1},
    '{OP_SEARCH, LTR_B,      1'b0, 1'b1, 1'b0, 12'd0, 16'd0, 1'b0},
    '{OP_SEARCH, LTR_A,      1'b1, 1'b1, 1'b0, 12'd0, 16'd0, 1'b0},
    '{OP_INSERT, LTR_A,      1'b1, 1'b1, 1'b1, 12'd1, 16'd2, 1'b0},
    '{OP_INSERT, LTR_C,      1'b0, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{OP_SEARCH, LTR_C,      1'b1, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{OP_INSERT, LTR_Q,      1'b1, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{OP_SEARCH, LTR_Q,      1'b1, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{OP_INSERT, LTR_Z,      1'b0, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0},
    '{OP_INSERT, LTR_A,      1'b1, 1'b0, 1'b0, 12'd0, 16'd0, 1'b0}
  };

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  opcode    = 1'b0;
  logic [LETTER_W-1:0]   letter    = '0;
  logic                  word_end  = 1'b0;
  logic                  out_ready = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  present;
  logic [NODE_OUT_W-1:0] node_index;
  logic [COUNT_W-1:0]    word_count;
  logic                  table_full;
  logic                  last;

  // bench copy of the trie
  bit [NODE_OUT_W-1:0] trie_child [0:NODES*ALPHA-1];
  bit [COUNT_W-1:0]    trie_ends  [0:NODES-1];
  int                  trie_nodes  = 0;
  int                  trie_cursor = 0;
  bit                  trie_missed = 1'b0;

  result_t trie_results_q [$];
  answer_t row_answer_q   [$];
  word_t   dict           [$];

  int errors        = 0;
  int quiet_cycles  = 0;
  int letters_sent  = 0;
  int burst_left    = 0;
  bit bursty        = 1'b0;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;
  bit pause_done    = 1'b0;

  trie_insert_and_prefix_search dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .letter     (letter),
    .word_end   (word_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .present    (present),
    .node_index (node_index),
    .word_count (word_count),
    .table_full (table_full),
    .last       (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t trie_walk(input op_e op, input logic [LETTER_W-1:0] ltr,
                                        input logic we);
    result_t r;
    int      slot;
    int      node;
    bit      ok;
    r      = '0;
    r.last = we;
    node   = 0;
    if (!trie_missed) begin
      ok   = ltr < ALPHA;
      slot = trie_cursor * ALPHA + int'(ltr);
      if (ok && trie_child[slot] != 0) begin
        r.present = 1'b1;
        node      = int'(trie_child[slot]);
      end else if (op == OP_INSERT && ok && trie_nodes + 1 < NODES) begin
        trie_nodes++;
        node             = trie_nodes;
        trie_child[slot] = NODE_OUT_W'(node);
        trie_ends[node]  = '0;
      end
      if (node != 0) begin
        // saturate the word count
        if (op == OP_INSERT && we && trie_ends[node] != {COUNT_W{1'b1}})
          trie_ends[node]++;
        r.node_index = NODE_OUT_W'(node);
        r.word_count = trie_ends[node];
        trie_cursor  = node;
      end else begin
        trie_missed  = 1'b1;
        r.table_full = (op == OP_INSERT);
      end
    end else begin
      r.table_full = (op == OP_INSERT);
    end
    if (we) begin
      trie_cursor = 0;
      trie_missed = 1'b0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      errors++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    result_t pred;
    result_t got;
    answer_t ans;
    if (!rst && in_valid && in_ready) begin
      ans  = row_answer_q.pop_front();
      pred = trie_walk(op_e'(opcode), letter, word_end);
      trie_results_q.push_back(ans.known ? ans.res : pred);
    end
    if (!rst && out_valid && out_ready) begin
      got = {present, node_index, word_count, table_full, last};
      if (trie_results_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        pred = trie_results_q.pop_front();
        check_field("present",    32'(pred.present),    32'(got.present));
        check_field("node_index", 32'(pred.node_index), 32'(got.node_index));
        check_field("word_count", 32'(pred.word_count), 32'(got.word_count));
        check_field("table_full", 32'(pred.table_full), 32'(got.table_full));
        check_field("last",       32'(pred.last),       32'(got.last));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : receiver
    int mode;
    int run_len;
    int i;
    forever begin
      if (hold_req) begin
        // long hold-off: let the block back up onto its input
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        mode    = $urandom_range(0, 2);
        run_len = $urandom_range(1, 40);
        for (i = 0; i < run_len; i++) begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 7) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic logic [LETTER_W-1:0] random_letter(input bit narrow);
    if ($urandom_range(0, 49) == 0)
      return LETTER_W'($urandom_range(ALPHA, (1 << LETTER_W) - 1));
    return narrow ? LETTER_W'($urandom_range(0, 3)) : LETTER_W'($urandom_range(0, ALPHA - 1));
  endfunction

  function automatic word_t random_word(input int max_len);
    word_t w;
    bit    narrow;
    int    i;
    // a narrow alphabet makes words share prefixes
    narrow = 1'($urandom_range(0, 1));
    w.len  = 4'($urandom_range(1, max_len));
    for (i = 0; i < 16; i++)
      w.ltr[i] = random_letter(narrow);
    return w;
  endfunction

  task automatic offer(input op_e op, input logic [LETTER_W-1:0] ltr, input logic we,
                       input answer_t ans);
    int gap;
    if (bursty && burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0)
      burst_left--;
    row_answer_q.push_back(ans);
    in_valid <= 1'b1;
    opcode   <= op;
    letter   <= ltr;
    word_end <= we;
    do @(posedge clk); while (!in_ready);
    letters_sent++;
  endtask

  task automatic send_word(input op_e op, input word_t w);
    int i;
    for (i = 0; i < w.len; i++)
      offer(op, w.ltr[i], i == w.len - 1, NO_ANSWER);
  endtask

  task automatic wait_until_answered();
    in_valid <= 1'b0;
    do @(posedge clk); while (trie_results_q.size() != 0);
  endtask

  task automatic random_mix(input int count);
    int    stop;
    int    pick;
    int    n;
    int    i;
    word_t w;
    stop = letters_sent + count;
    while (letters_sent < stop) begin
      if (!hold_done && letters_sent >= HOLD_AT) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && letters_sent >= PAUSE_AT) begin
        wait_until_answered();
        pause_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40 || dict.size() == 0) begin
        w = random_word(6);
        if (dict.size() < DICT_SIZE)
          dict.push_back(w);
        else
          dict[$urandom_range(0, DICT_SIZE - 1)] = w;
        send_word(OP_INSERT, w);
      end else if (pick < 50) begin
        // re-insert a stored word to bump its count
        send_word(OP_INSERT, dict[$urandom_range(0, dict.size() - 1)]);
      end else if (pick < 80) begin
        w     = dict[$urandom_range(0, dict.size() - 1)];
        w.len = 4'($urandom_range(1, w.len));
        send_word(OP_SEARCH, w);
      end else if (pick < 93) begin
        send_word(OP_SEARCH, random_word(6));
      end else begin
        // stray letters: any opcode, any code, word end or not
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
          offer(op_e'(1'($urandom_range(0, 1))),
                LETTER_W'($urandom_range(0, (1 << LETTER_W) - 1)),
                1'($urandom_range(0, 1)), NO_ANSWER);
      end
    end
  endtask

  initial begin : stimulus
    int      i;
    answer_t ans;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < NUM_STEPS; i++) begin
      ans.known = directed_steps[i].known;
      ans.res   = {directed_steps[i].present, directed_steps[i].node,
                   directed_steps[i].count, directed_steps[i].full, directed_steps[i].we};
      offer(directed_steps[i].op, directed_steps[i].ltr, directed_steps[i].we, ans);
    end
    wait_until_answered();

    bursty = 1'b1;
    random_mix(RANDOM_ITEMS);

    wait_until_answered();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (trie_results_q.size() != 0) begin
      $error("%0d results never arrived", trie_results_q.size());
      errors++;
    end
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
hdl/trie_pkg.sv
hdl/trie_ram.sv
hdl/trie_ctrl.sv
hdl/trie_dp.sv
hdl/trie_insert_and_prefix_search.sv
hdl/trie_chk.sv
verif/tb_trie_insert_and_prefix_search.sv
